@@ rtl/slfp_pkg.sv @@
// ---------------------------------------------------------------------------
// slfp_pkg: shared types and constants of the sync/length frame parser
// Holds the phase encoding, register map, framing constants and the structs
// that carry parser state, configuration and results between modules.
// ---------------------------------------------------------------------------
package slfp_pkg;

   // Fixed framing overhead: sync, type, two size bytes and the tail byte.
   localparam int unsigned FRAME_OVERHEAD = 5;

   // Register map, indexed by paddr[3:2].
   localparam logic [1:0] REG_SYNC    = 2'd0;
   localparam logic [1:0] REG_VERSION = 2'd1;
   localparam logic [1:0] REG_MAX     = 2'd2;

   // Register reset values.
   localparam logic [7:0]  SYNC_RESET    = 8'd126;
   localparam logic [1:0]  VERSION_RESET = 2'd0;
   localparam logic [15:0] MAX_RESET     = 16'd59;

   // Parser phase, also reported as the status of each byte.
   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_TYPE = 3'd1,
      PH_SIZE = 3'd2,
      PH_DATA = 3'd3,
      PH_TAIL = 3'd4,
      PH_DONE = 3'd5,
      PH_ERR  = 3'd6
   } phase_type;

   // Parser state carried from one byte to the next.
   typedef struct packed {
      phase_type   phase;
      logic [15:0] frame_length;
      logic        size_high_next;
      logic [15:0] size_field;
      logic [15:0] payload_count;
      logic [5:0]  type_bits;
   } state_type;

   // Configuration register contents.
   typedef struct packed {
      logic [7:0]  sync_value;
      logic [1:0]  version_value;
      logic [15:0] max_payload;
   } cfg_type;

   // Result of one byte.
   typedef struct packed {
      phase_type   status;
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic [5:0]  frame_type;
      logic [15:0] frame_size;
   } result_type;

endpackage

@@ rtl/sync_length_frame_parser_core.sv @@
// ---------------------------------------------------------------------------
// sync_length_frame_parser_core: sync/type/size/payload/tail frame parser
//
//   Channel  Direction  Handshake          Contents
//   req      in         req_valid/stall    one received byte
//   rsp      out        rsp_valid/stall    status, payload byte, type, size
//   csr      in/out     APB psel/penable   sync, version, max payload
//
// One byte per cycle sustained while rsp is not stalled; each byte is held in the input
// register and then sits in the result register until taken.
// The rate is set by the combinational parser state update between the two.
// Synchronous active-high reset clears state and both stages and loads the register reset values.
// A stall on rsp backs up into req_stall only once both stages are full.
// ---------------------------------------------------------------------------
module sync_length_frame_parser_core (
   input  logic        clock,
   input  logic        reset,
   // Byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // Result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic [5:0]  rsp_frame_type,
   output logic [15:0] rsp_frame_size,
   // Configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import slfp_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  state_ff;
   state_type  state_in;
   state_type  state_step;
   result_type result_step;
   result_type result_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       advance;
   logic       csr_write;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (paddr[3:2])
            REG_SYNC:    cfg_in.sync_value    = pwdata[7:0];
            REG_VERSION: cfg_in.version_value = pwdata[1:0];
            REG_MAX:     cfg_in.max_payload   = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SYNC:    prdata = {24'd0, cfg_ff.sync_value};
         REG_VERSION: prdata = {30'd0, cfg_ff.version_value};
         REG_MAX:     prdata = {16'd0, cfg_ff.max_payload};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value    <= SYNC_RESET;
         cfg_ff.version_value <= VERSION_RESET;
         cfg_ff.max_payload   <= MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage control: the input stage moves on when the result stage is free
   // or its transaction is being taken.
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input byte register.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Parser update for the byte in the input stage.
   slfp_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .rx_byte    (in_byte_ff),
      .state_next (state_step),
      .result     (result_step)
   );

   assign state_in = advance ? state_step : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_HUNT;
         state_ff.frame_length   <= '0;
         state_ff.size_high_next <= 1'b0;
         state_ff.size_field     <= '0;
         state_ff.payload_count  <= '0;
         state_ff.type_bits      <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_step;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = result_ff.status;
   assign rsp_payload_byte  = result_ff.payload_byte;
   assign rsp_payload_valid = result_ff.payload_valid;
   assign rsp_frame_type    = result_ff.frame_type;
   assign rsp_frame_size    = result_ff.frame_size;

   // A payload byte always leaves the parser in the data or tail phase.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload_valid) |->
         (rsp_status == PH_DATA || rsp_status == PH_TAIL))
      else $error("payload byte reported outside the data phase");

   // A byte that is not payload carries a zero payload field.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload_valid) |-> (rsp_payload_byte == 8'd0))
      else $error("non-payload result carries a payload byte");

   // The type phase is entered only from a sync byte, which restarts the count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_TYPE) |-> (state_ff.frame_length == 16'd1))
      else $error("type phase with a stale frame length");

   // A pending result leaves only when it has been taken.
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> ($past(reset) || $past(!rsp_stall)))
      else $error("result transaction dropped while stalled");

endmodule

@@ rtl/slfp_step.sv @@
// ---------------------------------------------------------------------------
// slfp_step: per-byte next-state logic of the frame parser
// Combinational update of the parser state for one received byte, together
// with the result transaction that byte produces.
// ---------------------------------------------------------------------------
module slfp_step (
   input  slfp_pkg::state_type  state,
   input  slfp_pkg::cfg_type    cfg,
   input  logic [7:0]           rx_byte,
   output slfp_pkg::state_type  state_next,
   output slfp_pkg::result_type result
);
   import slfp_pkg::*;

   logic [16:0] limit_sum;
   logic [15:0] limit;
   logic [16:0] size_max;
   phase_type   phase_eff;
   logic [15:0] length_eff;
   logic [15:0] size_full;
   logic        size_bad;
   logic [15:0] count_inc;
   logic [16:0] tail_expect;
   phase_type   phase_next;

   // Length limit saturates at sixteen bits.
   assign limit_sum = {1'b0, cfg.max_payload} + 17'(FRAME_OVERHEAD);
   assign limit     = limit_sum[16] ? 16'hFFFF : limit_sum[15:0];
   assign size_max  = limit_sum;

   // Length counter; an overrun drops the frame and the byte is hunted.
   // A finished frame also returns to hunting.
   always_comb begin
      if (state.frame_length < limit) begin
         length_eff = state.frame_length + 16'd1;
         phase_eff  = state.phase;
      end else begin
         length_eff = '0;
         phase_eff  = PH_ERR;
      end
      if (phase_eff == PH_ERR || phase_eff == PH_DONE) begin
         phase_eff  = PH_HUNT;
         length_eff = '0;
      end
   end

   // Size assembled from the high byte and the stored low byte.
   assign size_full   = {rx_byte, state.size_field[7:0]};
   assign size_bad    = (size_full < 16'(FRAME_OVERHEAD)) || ({1'b0, size_full} > size_max);
   assign count_inc   = state.payload_count + 16'd1;
   assign tail_expect = {1'b0, state.size_field} + 17'(FRAME_OVERHEAD);

   // Next phase.
   always_comb begin
      case (phase_eff)
         PH_HUNT: begin
            phase_next = (rx_byte == cfg.sync_value) ? PH_TYPE : PH_HUNT;
         end
         PH_TYPE: begin
            phase_next = (rx_byte[7:6] != cfg.version_value) ? PH_ERR : PH_SIZE;
         end
         PH_SIZE: begin
            if (!state.size_high_next) begin
               phase_next = PH_SIZE;
            end else begin
               phase_next = size_bad ? PH_ERR : PH_DATA;
            end
         end
         PH_DATA: begin
            phase_next = (count_inc >= state.size_field) ? PH_TAIL : PH_DATA;
         end
         PH_TAIL: begin
            phase_next = ({1'b0, length_eff} != tail_expect) ? PH_ERR : PH_DONE;
         end
         default: begin
            phase_next = PH_ERR;
         end
      endcase
   end

   // Counters, captured fields and the result.
   always_comb begin
      state_next              = state;
      state_next.phase        = phase_next;
      state_next.frame_length = length_eff;
      result.payload_valid    = 1'b0;
      result.payload_byte     = '0;
      case (phase_eff)
         PH_HUNT: begin
            if (rx_byte == cfg.sync_value) begin
               state_next.frame_length   = 16'd1;
               state_next.size_high_next = 1'b0;
               state_next.payload_count  = '0;
            end
         end
         PH_TYPE: begin
            if (rx_byte[7:6] == cfg.version_value) begin
               state_next.type_bits      = rx_byte[5:0];
               state_next.size_high_next = 1'b0;
            end
         end
         PH_SIZE: begin
            if (!state.size_high_next) begin
               state_next.size_field     = {8'd0, rx_byte};
               state_next.size_high_next = 1'b1;
            end else begin
               state_next.size_field = size_full;
               if (!size_bad) begin
                  state_next.size_high_next = 1'b0;
                  state_next.payload_count  = '0;
               end
            end
         end
         PH_DATA: begin
            result.payload_valid     = 1'b1;
            result.payload_byte      = rx_byte;
            state_next.payload_count = (count_inc >= state.size_field) ? 16'd0 : count_inc;
         end
         default: begin
         end
      endcase
      result.status     = phase_next;
      result.frame_type = state_next.type_bits;
      result.frame_size = state_next.size_field;
   end

endmodule
